[sv/sasp_pkg.sv]
package sasp_pkg;

	// Field widths
	localparam int FmtW       = 2;
	localparam int MaxWidthW  = 15;
	localparam int DimW       = 12;
	localparam int SrcStrideW = 14;
	localparam int ColorW     = 32;
	localparam int StrideW    = 16;
	localparam int OffsetW    = 32;
	localparam int XW         = 17;
	localparam int YW         = 16;
	localparam int AreaW      = StrideW + DimW;
	localparam int CfgIndexW  = 1;
	localparam int CfgDataW   = 15;

	// Reset value of the shelf width register
	localparam logic [MaxWidthW-1:0] MAX_WIDTH_RESET = 15'd4096;

	// Alpha handling for the ass format
	localparam logic [ColorW-1:0] ALPHA_KEEP_MASK = 32'hffffff00;
	localparam logic [7:0]        ALPHA_FULL      = 8'hff;

	typedef enum logic [FmtW-1:0] {
		FMT_NONE    = 2'd0,
		FMT_ASS     = 2'd1,
		FMT_RGBA    = 2'd2,
		FMT_INDEXED = 2'd3
	} pix_fmt_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_PIXEL_FORMAT      = 1'b0,
		REG_MAX_TEXTURE_WIDTH = 1'b1
	} cfg_reg_t;

	// Part as taken from the input channel
	typedef struct packed {
		logic                  first_part;
		logic                  last_part;
		logic [DimW-1:0]       part_height;
		logic [SrcStrideW-1:0] source_stride;
		logic [ColorW-1:0]     ass_color;
	} part_t;

	// Fields that ride along the stride pipeline untouched
	typedef struct packed {
		logic              first_part;
		logic              last_part;
		logic [DimW-1:0]   part_height;
		logic [ColorW-1:0] color_out;
	} meta_t;

	// Stride results handed to the shelf packer
	typedef struct packed {
		meta_t              meta;
		logic [StrideW-1:0] stride_bytes;
		logic [StrideW-1:0] stride_pixels;
	} stride_item_t;

	typedef struct packed {
		logic [StrideW-1:0] dest_stride_bytes;
		logic [StrideW-1:0] dest_stride_pixels;
		logic [OffsetW-1:0] data_offset;
		logic [XW-1:0]      atlas_x;
		logic [YW-1:0]      atlas_y;
		logic [ColorW-1:0]  color_out;
		logic [XW-1:0]      sheet_width;
		logic [YW-1:0]      sheet_height;
		logic [StrideW-1:0] max_stride_pixels;
		logic [DimW-1:0]    max_part_height;
		logic               frame_done;
	} result_t;

	// Source stride scaled by the per-format byte factor (0, 1, 1, 4)
	function automatic logic [StrideW-1:0] raw_stride(pix_fmt_t fmt,
			logic [SrcStrideW-1:0] src);
		logic [StrideW-1:0] r;
		case (fmt)
			FMT_NONE:    r = '0;
			FMT_ASS:     r = StrideW'(src);
			FMT_RGBA:    r = StrideW'(src);
			FMT_INDEXED: r = {src, 2'b00};
			default:     r = '0;
		endcase
		return r;
	endfunction

	// ass parts get the alpha byte inverted, everything else reports zero
	function automatic logic [ColorW-1:0] ass_alpha(pix_fmt_t fmt,
			logic [ColorW-1:0] color);
		logic [ColorW-1:0] c;
		c = '0;
		if (fmt == FMT_ASS) begin
			c = (color & ALPHA_KEEP_MASK) | ColorW'(ALPHA_FULL - color[7:0]);
		end
		return c;
	endfunction

endpackage

[sv/sasp_part_if.sv]
interface sasp_part_if;
	import sasp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  first_part;
	logic                  last_part;
	logic [DimW-1:0]       part_width;
	logic [DimW-1:0]       part_height;
	logic [SrcStrideW-1:0] source_stride;
	logic [ColorW-1:0]     ass_color;

	modport source (
		output valid, first_part, last_part, part_width, part_height,
			source_stride, ass_color,
		input  ready
	);

	modport sink (
		input  valid, first_part, last_part, part_width, part_height,
			source_stride, ass_color,
		output ready
	);

endinterface

[sv/sasp_result_if.sv]
interface sasp_result_if;
	import sasp_pkg::*;

	logic               valid;
	logic               ready;
	logic [StrideW-1:0] dest_stride_bytes;
	logic [StrideW-1:0] dest_stride_pixels;
	logic [OffsetW-1:0] data_offset;
	logic [XW-1:0]      atlas_x;
	logic [YW-1:0]      atlas_y;
	logic [ColorW-1:0]  color_out;
	logic [XW-1:0]      sheet_width;
	logic [YW-1:0]      sheet_height;
	logic [StrideW-1:0] max_stride_pixels;
	logic [DimW-1:0]    max_part_height;
	logic               frame_done;

	modport source (
		output valid, dest_stride_bytes, dest_stride_pixels, data_offset, atlas_x,
			atlas_y, color_out, sheet_width, sheet_height, max_stride_pixels,
			max_part_height, frame_done,
		input  ready
	);

	modport sink (
		input  valid, dest_stride_bytes, dest_stride_pixels, data_offset, atlas_x,
			atlas_y, color_out, sheet_width, sheet_height, max_stride_pixels,
			max_part_height, frame_done,
		output ready
	);

endinterface

[sv/sasp_align.sv]
module sasp_align #(
	parameter int ROW_ALIGN_BYTES = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sasp_pkg::pix_fmt_t     fmt,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sasp_pkg::part_t        in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sasp_pkg::stride_item_t out_item
);
	import sasp_pkg::*;

	// Rounding to a multiple of ROW_ALIGN_BYTES uses a reciprocal multiply
	// that is exact for every numerator below 2**NumW.
	localparam int NumW       = StrideW + 1;
	localparam int AlignLog   = $clog2(ROW_ALIGN_BYTES);
	localparam int RecipShift = NumW + AlignLog;
	localparam int RecipW     = NumW + 1;
	localparam int QuoProdW   = NumW + RecipW;
	localparam logic [RecipW-1:0] RecipMul =
		RecipW'(((longint'(1) << RecipShift) + ROW_ALIGN_BYTES - 1) / ROW_ALIGN_BYTES);
	localparam logic [NumW-1:0] NumBias = NumW'(ROW_ALIGN_BYTES - 1);
	localparam logic [NumW-1:0] AlignW  = NumW'(ROW_ALIGN_BYTES);
	// largest multiple of the alignment that still fits the stride field
	localparam logic [NumW-1:0] StrideCap =
		NumW'(65535 - (65535 % ROW_ALIGN_BYTES));

	logic            v_s1, v_s2, v_s3;
	logic            rdy_s1, rdy_s2, rdy_s3;
	part_t           item_s1;
	meta_t           meta_s2;
	logic            pix_shift_s2;
	logic [NumW-1:0] quo_s2;
	stride_item_t    item_s3;

	logic [StrideW-1:0]  raw;
	logic [NumW-1:0]     numer;
	logic [QuoProdW-1:0] quo_prod;
	logic [NumW-1:0]     rounded;
	logic [StrideW-1:0]  stride_b;
	logic [StrideW-1:0]  stride_p;

	// Stage ready chain: a stage takes a new item when empty or draining
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1 logic: byte stride before rounding, quotient by reciprocal
	always_comb begin
		raw      = raw_stride(fmt, item_s1.source_stride);
		numer    = NumW'(raw) + NumBias;
		quo_prod = QuoProdW'(numer) * QuoProdW'(RecipMul);
	end

	// Stage 2 logic: back to bytes, saturate, convert to pixels
	always_comb begin
		rounded  = NumW'(quo_s2 * AlignW);
		stride_b = (rounded > StrideCap) ? StrideCap[StrideW-1:0] : rounded[StrideW-1:0];
		stride_p = pix_shift_s2 ? (stride_b >> 2) : stride_b;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (rdy_s2 && v_s1) begin
			meta_s2.first_part  <= item_s1.first_part;
			meta_s2.last_part   <= item_s1.last_part;
			meta_s2.part_height <= item_s1.part_height;
			meta_s2.color_out   <= ass_alpha(fmt, item_s1.ass_color);
			pix_shift_s2        <= (fmt == FMT_RGBA) || (fmt == FMT_INDEXED);
			quo_s2              <= NumW'(quo_prod >> RecipShift);
		end
		if (rdy_s3 && v_s2) begin
			item_s3.meta          <= meta_s2;
			item_s3.stride_bytes  <= stride_b;
			item_s3.stride_pixels <= stride_p;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

[sv/sasp_shelf.sv]
module sasp_shelf (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [sasp_pkg::MaxWidthW-1:0]     max_width,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sasp_pkg::stride_item_t             in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sasp_pkg::result_t                  out_result
);
	import sasp_pkg::*;

	logic               v_s4;
	logic               rdy_s4;
	logic               load;
	stride_item_t       item_s4;
	logic [AreaW-1:0]   area_s4;
	logic               out_valid_q;
	result_t            result_q;

	// Running frame state and persistent maxima
	logic [OffsetW-1:0] next_offset_q;
	logic [XW-1:0]      cursor_x_q;
	logic [YW-1:0]      cursor_y_q;
	logic [DimW-1:0]    row_height_q;
	logic [XW-1:0]      sheet_width_q;
	logic [StrideW-1:0] max_stride_q;
	logic [DimW-1:0]    max_height_q;

	logic [OffsetW-1:0] off_cur;
	logic [OffsetW:0]   off_sum;
	logic [OffsetW-1:0] off_nxt;
	logic [XW-1:0]      cx;
	logic [YW-1:0]      cy;
	logic [DimW-1:0]    rh;
	logic [XW-1:0]      sw;
	logic [XW:0]        wrap_sum;
	logic               wrap;
	logic [YW:0]        cy_sum;
	logic [YW-1:0]      cy_w;
	logic [DimW-1:0]    rh_w;
	logic [DimW-1:0]    rh_n;
	logic [XW:0]        cx_sum;
	logic [XW-1:0]      cx_n;
	logic [XW-1:0]      sw_n;
	logic [YW:0]        sh_sum;
	logic [YW-1:0]      sheet_h;
	logic [StrideW-1:0] max_s_n;
	logic [DimW-1:0]    max_h_n;
	logic [StrideW-1:0] sp;
	logic [DimW-1:0]    h;

	assign out_valid  = out_valid_q;
	assign out_result = result_q;
	assign load       = v_s4 && (!out_valid_q || out_ready);
	assign rdy_s4     = !v_s4 || load;
	assign in_ready   = rdy_s4;

	// Shelf placement and offset update for the part in stage 4
	always_comb begin
		sp = item_s4.stride_pixels;
		h  = item_s4.meta.part_height;

		// a first part starts from an empty frame
		off_cur = item_s4.meta.first_part ? '0 : next_offset_q;
		cx      = item_s4.meta.first_part ? '0 : cursor_x_q;
		cy      = item_s4.meta.first_part ? '0 : cursor_y_q;
		rh      = item_s4.meta.first_part ? '0 : row_height_q;
		sw      = item_s4.meta.first_part ? '0 : sheet_width_q;

		off_sum = (OffsetW+1)'(off_cur) + (OffsetW+1)'(area_s4);
		off_nxt = off_sum[OffsetW] ? '1 : off_sum[OffsetW-1:0];

		// new shelf when the part would run past the shelf width
		wrap_sum = (XW+1)'(cx) + (XW+1)'(sp);
		wrap     = wrap_sum > (XW+1)'(max_width);
		cy_sum   = (YW+1)'(cy) + (YW+1)'(rh);
		cy_w     = !wrap ? cy : (cy_sum[YW] ? '1 : cy_sum[YW-1:0]);
		rh_w     = wrap ? '0 : rh;
		rh_n     = (h > rh_w) ? h : rh_w;

		cx_sum   = wrap ? (XW+1)'(sp) : wrap_sum;
		cx_n     = cx_sum[XW] ? '1 : cx_sum[XW-1:0];
		sw_n     = (cx_n > sw) ? cx_n : sw;
		sh_sum   = (YW+1)'(cy_w) + (YW+1)'(rh_n);
		sheet_h  = sh_sum[YW] ? '1 : sh_sum[YW-1:0];

		max_s_n  = (sp > max_stride_q) ? sp : max_stride_q;
		max_h_n  = (h > max_height_q) ? h : max_height_q;
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4          <= 1'b0;
			out_valid_q   <= 1'b0;
			next_offset_q <= '0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			row_height_q  <= '0;
			sheet_width_q <= '0;
			max_stride_q  <= '0;
			max_height_q  <= '0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (load) begin
				out_valid_q   <= 1'b1;
				next_offset_q <= off_nxt;
				cursor_x_q    <= cx_n;
				cursor_y_q    <= cy_w;
				row_height_q  <= rh_n;
				sheet_width_q <= sw_n;
				max_stride_q  <= max_s_n;
				max_height_q  <= max_h_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 4 payload (byte area of the part) and result register
	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			item_s4 <= in_item;
			area_s4 <= AreaW'(in_item.stride_bytes) * AreaW'(in_item.meta.part_height);
		end
		if (load) begin
			result_q.dest_stride_bytes  <= item_s4.stride_bytes;
			result_q.dest_stride_pixels <= sp;
			result_q.data_offset        <= off_cur;
			result_q.atlas_x            <= wrap ? '0 : cx;
			result_q.atlas_y            <= cy_w;
			result_q.color_out          <= item_s4.meta.color_out;
			result_q.sheet_width        <= sw_n;
			result_q.sheet_height       <= sheet_h;
			result_q.max_stride_pixels  <= max_s_n;
			result_q.max_part_height    <= max_h_n;
			result_q.frame_done         <= item_s4.meta.last_part;
		end
	end

endmodule

[sv/subtitle_atlas_shelf_packer_core.sv]
// Subtitle atlas shelf packer: one result per bitmap part, in order. Parts
// are taken at a sustained rate of one per clock while the result side does
// not stall; a part passes the input register, reciprocal-multiply
// rounding, stride, byte-area multiply and shelf update into the result
// register in that order. The rate is set by the shelf and offset state
// update, which is combinational from the registered frame state.
// Configuration writes must be made with no part in flight. There is no
// start-up sweep: parts are taken from the first cycle after reset.
module subtitle_atlas_shelf_packer_core #(
	parameter int ROW_ALIGN_BYTES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [sasp_pkg::CfgIndexW-1:0]    wr_index,
	input  logic [sasp_pkg::CfgDataW-1:0]     wr_data,
	sasp_part_if.sink                         part,
	sasp_result_if.source                     result
);
	import sasp_pkg::*;

	logic [FmtW-1:0]      pixel_format_q;
	logic [MaxWidthW-1:0] max_texture_width_q;
	part_t                part_item;
	logic                 mid_valid;
	logic                 mid_ready;
	stride_item_t         mid_item;
	result_t              res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q      <= FMT_NONE;
			max_texture_width_q <= MAX_WIDTH_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_PIXEL_FORMAT:      pixel_format_q      <= wr_data[FmtW-1:0];
				REG_MAX_TEXTURE_WIDTH: max_texture_width_q <= wr_data[MaxWidthW-1:0];
				default: ;
			endcase
		end
	end

	// Part width does not affect any result
	always_comb begin
		part_item.first_part    = part.first_part;
		part_item.last_part     = part.last_part;
		part_item.part_height   = part.part_height;
		part_item.source_stride = part.source_stride;
		part_item.ass_color     = part.ass_color;
	end

	sasp_align #(
		.ROW_ALIGN_BYTES(ROW_ALIGN_BYTES)
	) u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.fmt      (pix_fmt_t'(pixel_format_q)),
		.in_valid (part.valid),
		.in_ready (part.ready),
		.in_item  (part_item),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.out_item (mid_item)
	);

	sasp_shelf u_shelf (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_width (max_texture_width_q),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_item   (mid_item),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_result(res)
	);

	// Result channel payload
	assign result.dest_stride_bytes  = res.dest_stride_bytes;
	assign result.dest_stride_pixels = res.dest_stride_pixels;
	assign result.data_offset        = res.data_offset;
	assign result.atlas_x            = res.atlas_x;
	assign result.atlas_y            = res.atlas_y;
	assign result.color_out          = res.color_out;
	assign result.sheet_width        = res.sheet_width;
	assign result.sheet_height       = res.sheet_height;
	assign result.max_stride_pixels  = res.max_stride_pixels;
	assign result.max_part_height    = res.max_part_height;
	assign result.frame_done         = res.frame_done;

`ifndef SYNTHESIS
	// Maxima never shrink from one result to the next
	a_max_height_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && $past(result.valid && result.ready))
		|-> (result.max_part_height >= $past(result.max_part_height)))
		else $error("max_part_height decreased between results");

	a_max_stride_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && $past(result.valid && result.ready))
		|-> (result.max_stride_pixels >= $past(result.max_stride_pixels)))
		else $error("max_stride_pixels decreased between results");

	// The origin of a placed part always lies inside the reported sheet
	a_sheet_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.sheet_width >= result.atlas_x)
			&& (result.sheet_height >= result.atlas_y))
		else $error("sheet does not cover placed part");
`endif

endmodule
